@@ sv/rpk_pkg.sv @@
// Shared types and sizing constants for the subword repacker.
// Used by every module of the block; depends on nothing else.
package rpk_pkg;

	// Word geometry
	localparam int WORD_LIMBS      = 4;
	localparam int CHUNK_BITS      = 64;
	localparam int CHUNKS_PER_WORD = 4;
	localparam int LIMB_BITS       = 64;
	localparam int PORT_LIMBS      = 4;
	localparam int USED_BITS       = WORD_LIMBS * LIMB_BITS;
	localparam int PORT_BITS       = PORT_LIMBS * LIMB_BITS;

	// Lanes that touch at least one bit of the word
	localparam int CHUNKS_IN_WORD  = (USED_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int LANES           = (CHUNKS_PER_WORD < CHUNKS_IN_WORD) ?
		CHUNKS_PER_WORD : CHUNKS_IN_WORD;

	// Field and internal widths
	localparam int FIELD_W    = 7;
	localparam int FIELD_VALS = 1 << FIELD_W;
	localparam int POS_W      = $clog2(CHUNK_BITS);
	localparam int CNT_W      = $clog2(CHUNK_BITS + 1);
	localparam int TWO_W      = CNT_W + 1;
	localparam int SUM_W      = ((TWO_W > FIELD_W) ? TWO_W : FIELD_W) + 1;

	// Pipeline depth, output register included
	localparam int STAGES = 6;

	typedef struct packed {
		logic [FIELD_W-1:0]   source_width;
		logic [FIELD_W-1:0]   target_width;
		logic [FIELD_W-1:0]   start_index;
		logic [LIMB_BITS-1:0] first_word_0;
		logic [LIMB_BITS-1:0] first_word_1;
		logic [LIMB_BITS-1:0] first_word_2;
		logic [LIMB_BITS-1:0] first_word_3;
		logic [LIMB_BITS-1:0] second_word_0;
		logic [LIMB_BITS-1:0] second_word_1;
		logic [LIMB_BITS-1:0] second_word_2;
		logic [LIMB_BITS-1:0] second_word_3;
	} item_t;

	typedef struct packed {
		logic [LIMB_BITS-1:0] packed_word_0;
		logic [LIMB_BITS-1:0] packed_word_1;
		logic [LIMB_BITS-1:0] packed_word_2;
		logic [LIMB_BITS-1:0] packed_word_3;
	} result_t;

	// Per-stage load strobes from the flow control
	typedef struct packed {
		logic [STAGES:1] load;
	} pipe_ctl_t;

	// Where one output bit of a chunk comes from
	typedef struct packed {
		logic             hit;
		logic             from_b;
		logic [POS_W-1:0] src;
	} pos_map_t;

	typedef pos_map_t [CHUNK_BITS-1:0] pos_map_vec_t;

endpackage

@@ sv/rpk_map.sv @@
// Bit map generator: turns widths and start index into a source bit for each
// output bit of a chunk. Shared by all lanes. Depends on rpk_pkg.
module rpk_map (
	input  logic                         clk,
	input  rpk_pkg::pipe_ctl_t           ctl,
	input  logic [rpk_pkg::FIELD_W-1:0]  source_width,
	input  logic [rpk_pkg::FIELD_W-1:0]  target_width,
	input  logic [rpk_pkg::FIELD_W-1:0]  start_index,
	output rpk_pkg::pos_map_vec_t        map_s4,
	output logic                         legal_s4
);
	import rpk_pkg::*;

	localparam int CMP_W = ((FIELD_W > CNT_W) ? FIELD_W : CNT_W) + 1;
	localparam logic [CMP_W-1:0] CHUNK_LIM = CMP_W'(CHUNK_BITS);

	// Constant tables, indexed by a width field
	logic [CNT_W-1:0]      n_tbl  [FIELD_VALS];
	logic [TWO_W-1:0]      jm_tbl [CHUNK_BITS][FIELD_VALS];
	logic [POS_W-1:0]      jp_tbl [CHUNK_BITS][FIELD_VALS];
	logic [POS_W-1:0]      rp_tbl [CHUNK_BITS][FIELD_VALS];
	logic [FIELD_VALS-1:0] cov_tbl [CHUNK_BITS];

	// Stage 1
	logic [CNT_W-1:0]      n_c;
	logic                  legal_c;
	logic [CNT_W-1:0]      n_s1;
	logic [TWO_W-1:0]      two_n_s1;
	logic [FIELD_W-1:0]    sw_s1;
	logic [FIELD_W-1:0]    tw_s1;
	logic [FIELD_W-1:0]    start_s1;
	logic                  legal_s1;
	logic                  narrow_s1;
	logic [CNT_W-1:0]      gap_s1;
	logic [TWO_W-1:0]      jm_s1 [CHUNK_BITS];
	logic [POS_W-1:0]      jp_s1 [CHUNK_BITS];
	logic [POS_W-1:0]      rp_s1 [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] cov_s1;

	// Stage 2
	logic [SUM_W-1:0]      sum_c  [CHUNK_BITS];
	logic [TWO_W-1:0]      wrap_c [CHUNK_BITS];
	logic [CNT_W-1:0]      idx_c  [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] fb_c;
	logic [CNT_W-1:0]      idx_s2 [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] fb_s2;
	logic [FIELD_W-1:0]    sw_s2;
	logic [FIELD_W-1:0]    tw_s2;
	logic                  legal_s2;
	logic                  narrow_s2;
	logic [CNT_W-1:0]      gap_s2;
	logic [POS_W-1:0]      jp_s2 [CHUNK_BITS];
	logic [POS_W-1:0]      rp_s2 [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] cov_s2;

	// Stage 3
	logic [POS_W-1:0]      off_c  [CHUNK_BITS];
	logic [POS_W-1:0]      off_s3 [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] fb_s3;
	logic                  legal_s3;
	logic                  narrow_s3;
	logic [CNT_W-1:0]      gap_s3;
	logic [POS_W-1:0]      jp_s3 [CHUNK_BITS];
	logic [POS_W-1:0]      rp_s3 [CHUNK_BITS];
	logic [CHUNK_BITS-1:0] cov_s3;

	// Stage 4
	pos_map_vec_t          map_c;

	// Build the tables; meaningless widths divide by one
	for (genvar t = 0; t < FIELD_VALS; t++) begin : g_div
		localparam int D = (t == 0 || t > CHUNK_BITS) ? 1 : t;
		localparam int N = CHUNK_BITS / D;
		assign n_tbl[t] = CNT_W'(N);
		for (genvar k = 0; k < CHUNK_BITS; k++) begin : g_pos
			localparam int JM  = k % (2 * N);
			localparam int JP  = k / D;
			localparam int RP  = k % D;
			localparam bit COV = (k < N * D);
			assign jm_tbl[k][t] = TWO_W'(JM);
			assign jp_tbl[k][t] = POS_W'(JP);
			assign rp_tbl[k][t] = POS_W'(RP);
			assign cov_tbl[k][t] = COV;
		end
	end

	// Check widths and start against the subword count
	assign n_c = n_tbl[source_width];
	assign legal_c = (source_width != '0) && (target_width != '0) &&
		(CMP_W'(source_width) <= CHUNK_LIM) && (CMP_W'(target_width) <= CHUNK_LIM) &&
		(SUM_W'(start_index) < SUM_W'({n_c, 1'b0}));

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			n_s1      <= n_c;
			two_n_s1  <= {n_c, 1'b0};
			sw_s1     <= source_width;
			tw_s1     <= target_width;
			start_s1  <= start_index;
			legal_s1  <= legal_c;
			narrow_s1 <= source_width < target_width;
			gap_s1    <= CNT_W'(target_width) - CNT_W'(source_width);
			for (int k = 0; k < CHUNK_BITS; k++) begin
				jm_s1[k]  <= jm_tbl[k][source_width];
				jp_s1[k]  <= jp_tbl[k][target_width];
				rp_s1[k]  <= rp_tbl[k][target_width];
				cov_s1[k] <= cov_tbl[k][target_width];
			end
		end
	end

	// Wrap the source index per output subword, then split first/second word
	always_comb begin
		for (int j = 0; j < CHUNK_BITS; j++) begin
			sum_c[j] = SUM_W'(jm_s1[j]) + SUM_W'(start_s1);
			if (sum_c[j] >= SUM_W'(two_n_s1)) begin
				wrap_c[j] = TWO_W'(sum_c[j] - SUM_W'(two_n_s1));
			end else begin
				wrap_c[j] = TWO_W'(sum_c[j]);
			end
			fb_c[j] = wrap_c[j] >= TWO_W'(n_s1);
			if (fb_c[j]) begin
				idx_c[j] = CNT_W'(wrap_c[j] - TWO_W'(n_s1));
			end else begin
				idx_c[j] = CNT_W'(wrap_c[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			idx_s2    <= idx_c;
			fb_s2     <= fb_c;
			sw_s2     <= sw_s1;
			tw_s2     <= tw_s1;
			legal_s2  <= legal_s1;
			narrow_s2 <= narrow_s1;
			gap_s2    <= gap_s1;
			jp_s2     <= jp_s1;
			rp_s2     <= rp_s1;
			cov_s2    <= cov_s1;
		end
	end

	// Source bit of the first output bit of each subword; the true value
	// always lands inside the chunk, so position-width arithmetic suffices
	always_comb begin
		for (int j = 0; j < CHUNK_BITS; j++) begin
			off_c[j] = POS_W'(idx_s2[j] * sw_s2) + POS_W'(sw_s2) - POS_W'(tw_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			off_s3    <= off_c;
			fb_s3     <= fb_s2;
			legal_s3  <= legal_s2;
			narrow_s3 <= narrow_s2;
			gap_s3    <= gap_s2;
			jp_s3     <= jp_s2;
			rp_s3     <= rp_s2;
			cov_s3    <= cov_s2;
		end
	end

	// Resolve each output bit; a narrow source leaves the low bits empty
	always_comb begin
		for (int p = 0; p < CHUNK_BITS; p++) begin
			map_c[p].src    = off_s3[jp_s3[p]] + rp_s3[p];
			map_c[p].from_b = fb_s3[jp_s3[p]];
			map_c[p].hit    = cov_s3[p] && (!narrow_s3 || (CNT_W'(rp_s3[p]) >= gap_s3));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			map_s4   <= map_c;
			legal_s4 <= legal_s3;
		end
	end

endmodule

@@ sv/rpk_lane.sv @@
// One repack lane: gathers the bits of one output chunk from the two source
// chunks through the shared bit map. Depends on rpk_pkg.
module rpk_lane (
	input  logic                           clk,
	input  rpk_pkg::pipe_ctl_t             ctl,
	input  rpk_pkg::pos_map_vec_t          map_s4,
	input  logic [rpk_pkg::CHUNK_BITS-1:0] first_s4,
	input  logic [rpk_pkg::CHUNK_BITS-1:0] second_s4,
	output logic [rpk_pkg::CHUNK_BITS-1:0] chunk_s5
);
	import rpk_pkg::*;

	logic [CHUNK_BITS-1:0] pick_c;

	// Select each output bit, zero where no subword covers it
	always_comb begin
		for (int p = 0; p < CHUNK_BITS; p++) begin
			if (!map_s4[p].hit) begin
				pick_c[p] = 1'b0;
			end else if (map_s4[p].from_b) begin
				pick_c[p] = second_s4[map_s4[p].src];
			end else begin
				pick_c[p] = first_s4[map_s4[p].src];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			chunk_s5 <= pick_c;
		end
	end

endmodule

@@ sv/rpk_merge.sv @@
// Merge stage: joins the lane chunks into one word, or passes the first
// source word through on illegal settings. Depends on rpk_pkg.
module rpk_merge (
	input  logic                                          clk,
	input  rpk_pkg::pipe_ctl_t                            ctl,
	input  logic [rpk_pkg::LANES*rpk_pkg::CHUNK_BITS-1:0] lanes_s5,
	input  logic [rpk_pkg::PORT_BITS-1:0]                 first_s5,
	input  logic                                          legal_s5,
	output rpk_pkg::result_t                              result_s6
);
	import rpk_pkg::*;

	localparam int LANE_BITS = LANES * CHUNK_BITS;

	logic [PORT_BITS-1:0] word_c;

	// Bits past the word stay zero; bits past the last lane are zero unless the first word passes through
	for (genvar b = 0; b < PORT_BITS; b++) begin : g_bit
		if (b >= USED_BITS) begin : g_off
			assign word_c[b] = 1'b0;
		end else if (b < LANE_BITS) begin : g_lane
			assign word_c[b] = legal_s5 ? lanes_s5[b] : first_s5[b];
		end else begin : g_rest
			assign word_c[b] = legal_s5 ? 1'b0 : first_s5[b];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			result_s6.packed_word_0 <= word_c[0*LIMB_BITS +: LIMB_BITS];
			result_s6.packed_word_1 <= word_c[1*LIMB_BITS +: LIMB_BITS];
			result_s6.packed_word_2 <= word_c[2*LIMB_BITS +: LIMB_BITS];
			result_s6.packed_word_3 <= word_c[3*LIMB_BITS +: LIMB_BITS];
		end
	end

endmodule

@@ sv/subword_repacker.sv @@
// Subword repacker top level: flow control, source word pipeline, bit map,
// lanes and merge stage. Depends on rpk_pkg, rpk_map, rpk_lane, rpk_merge.
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     item   (rpk_pkg::item_t)
//   result    out        result_valid / result_stall result (rpk_pkg::result_t)
//
// One word enters per cycle while item_stall is low; each word passes through
// four map stages, the lane gather stage and the merge output register.
// Stages move independently: a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up and input is taken while a result waits.
// item_stall rises only when all six stages hold a word and result_stall is high.
// arst_n clears the stage valid bits only; data registers are not reset.
module subword_repacker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rpk_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output rpk_pkg::result_t result
);
	import rpk_pkg::*;

	localparam logic [PORT_BITS-1:0] WORD_MASK =
		{PORT_BITS{1'b1}} >> (PORT_BITS - USED_BITS);

	logic [STAGES:1]             vld_q;
	logic [STAGES:1]             vld_d;
	logic [STAGES+1:1]           rdy;
	pipe_ctl_t                   ctl;

	logic [PORT_BITS-1:0]        first_c;
	logic [PORT_BITS-1:0]        second_c;
	logic [PORT_BITS-1:0]        first_s1, first_s2, first_s3, first_s4, first_s5;
	logic [PORT_BITS-1:0]        second_s1, second_s2, second_s3, second_s4;
	logic                        legal_s4;
	logic                        legal_s5;
	pos_map_vec_t                map_s4;
	logic [LANES*CHUNK_BITS-1:0] lanes_s5;

	// Ready ripples back from the output register
	always_comb begin
		rdy[STAGES+1] = !result_stall;
		for (int k = STAGES; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctl.load   = rdy[STAGES:1];
	assign item_stall = !rdy[1];
	assign result_valid = vld_q[STAGES];

	// Advance valid bits where a stage loads, hold the rest
	assign vld_d = (rdy[STAGES:1] & {vld_q[STAGES-1:1], item_valid}) |
		(~rdy[STAGES:1] & vld_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= vld_d;
		end
	end

	// Drop limbs past the word width on entry
	assign first_c = {item.first_word_3, item.first_word_2,
		item.first_word_1, item.first_word_0} & WORD_MASK;
	assign second_c = {item.second_word_3, item.second_word_2,
		item.second_word_1, item.second_word_0} & WORD_MASK;

	// Carry source words alongside the map stages
	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			first_s1  <= first_c;
			second_s1 <= second_c;
		end
		if (ctl.load[2]) begin
			first_s2  <= first_s1;
			second_s2 <= second_s1;
		end
		if (ctl.load[3]) begin
			first_s3  <= first_s2;
			second_s3 <= second_s2;
		end
		if (ctl.load[4]) begin
			first_s4  <= first_s3;
			second_s4 <= second_s3;
		end
		if (ctl.load[5]) begin
			first_s5 <= first_s4;
			legal_s5 <= legal_s4;
		end
	end

	rpk_map u_map (
		.clk          (clk),
		.ctl          (ctl),
		.source_width (item.source_width),
		.target_width (item.target_width),
		.start_index  (item.start_index),
		.map_s4       (map_s4),
		.legal_s4     (legal_s4)
	);

	// One lane per chunk; chunk bits past the word read as zero
	for (genvar c = 0; c < LANES; c++) begin : g_lane
		logic [CHUNK_BITS-1:0] a_c;
		logic [CHUNK_BITS-1:0] b_c;
		for (genvar k = 0; k < CHUNK_BITS; k++) begin : g_bit
			if (c * CHUNK_BITS + k < USED_BITS) begin : g_in
				assign a_c[k] = first_s4[c*CHUNK_BITS+k];
				assign b_c[k] = second_s4[c*CHUNK_BITS+k];
			end else begin : g_pad
				assign a_c[k] = 1'b0;
				assign b_c[k] = 1'b0;
			end
		end
		rpk_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.map_s4    (map_s4),
			.first_s4  (a_c),
			.second_s4 (b_c),
			.chunk_s5  (lanes_s5[c*CHUNK_BITS +: CHUNK_BITS])
		);
	end

	rpk_merge u_merge (
		.clk       (clk),
		.ctl       (ctl),
		.lanes_s5  (lanes_s5),
		.first_s5  (first_s5),
		.legal_s5  (legal_s5),
		.result_s6 (result)
	);

	// Input backs up only when every stage is occupied
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (&vld_q))
		else $error("input stalled with an empty stage");

	// A taken word with nothing leaving adds one word in flight
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && item_valid && !item_stall && !(result_valid && !result_stall)) |=>
		($countones(vld_q) == $past($countones(vld_q)) + 1))
		else $error("accepted word not tracked in the pipeline");

	// A delivered word with nothing entering removes one word in flight
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && !(item_valid && !item_stall) && result_valid && !result_stall) |=>
		($countones(vld_q) == $past($countones(vld_q)) - 1))
		else $error("delivered word not retired from the pipeline");

	// Simultaneous entry and exit keep the count
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(arst_n && item_valid && !item_stall && result_valid && !result_stall) |=>
		($countones(vld_q) == $past($countones(vld_q))))
		else $error("word count changed on simultaneous entry and exit");

endmodule
